/* rtl/pgsc_pkg.sv */
// Shared types and constants of the split-children lister.
`default_nettype none
package pgsc_pkg;

	localparam int PARENT_W   = 16;
	localparam int CHILD_W    = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OLD_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_COUNT = 2'd1;

	localparam int OLD_COUNT_RESET = 16;
	localparam int NEW_COUNT_RESET = 32;

	typedef struct packed {
		logic stop;
		logic keep;
	} eval_t;

endpackage
`default_nettype wire

/* rtl/pgsc_eval.sv */
// Candidate evaluation unit: forms one candidate and applies the stable-mod tests.
`default_nettype none
module pgsc_eval import pgsc_pkg::*; #(
	parameter int SW = 17
) (
	input  wire logic [SW-1:0] base,
	input  wire logic [SW-1:0] parent,
	input  wire logic [SW-1:0] oldc,
	input  wire logic [SW-1:0] newc,
	input  wire logic [SW-1:0] mask,
	input  wire logic [SW-1:0] prev,
	input  wire logic          prev_v,
	output logic      [SW-1:0] cand,
	output eval_t              flags
);

	logic [SW-1:0] low_bits;
	logic [SW-1:0] reduced;

	always_comb begin
		cand       = base | parent;
		low_bits   = cand & mask;
		reduced    = (low_bits < oldc) ? low_bits : (cand & (mask >> 1));
		flags.stop = (cand >= newc);
		flags.keep = !flags.stop && (cand >= oldc) && (cand != parent) &&
			(reduced == parent) && !(prev_v && (cand == prev));
	end

endmodule
`default_nettype wire

/* rtl/placement_group_split_children.sv */
// Top level of the split-children lister: config registers, sequencer, result register.
// Lists, in ascending order, the buckets that split off parent_bucket when the bucket
// count grows from old_bucket_count to new_bucket_count (linear hashing, stable-mod).
// A transaction is accepted when start is high and busy is low; for a valid parent and count
// pair busy then stays high while the shared evaluation unit tests one candidate multiplier
// per cycle. An invalid parent or count pair gives its empty result in the cycle after the
// accept with busy staying low. Each result is shown for one cycle with result_valid high
// and cannot be stalled; last marks the final result of a parent.
// The config channel is always ready and should be written only while busy is low.
`default_nettype none
module placement_group_split_children import pgsc_pkg::*; #(
	parameter int BUCKET_BITS  = 16,
	parameter int MAX_CHILDREN = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [BUCKET_BITS-1:0] cfg_data,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [PARENT_W-1:0]    parent_bucket,
	output logic                        result_valid,
	output logic                        has_child,
	output logic [CHILD_W-1:0]          child_bucket,
	output logic                        last,
	output logic                        truncated
);

	localparam int SW          = ((BUCKET_BITS > PARENT_W) ? BUCKET_BITS : PARENT_W) + 1;
	localparam int SMEAR_STEPS = $clog2(SW);
	localparam int CW          = $clog2(MAX_CHILDREN + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                   state_q;
	logic [BUCKET_BITS-1:0] oldc_q;
	logic [BUCKET_BITS-1:0] newc_q;
	logic [PARENT_W-1:0]    parent_q;
	logic [SW-1:0]          mask_q;
	logic [SW-1:0]          step_q;
	logic [SW-1:0]          base_q;
	logic [SW-1:0]          pend_q;
	logic                   pend_v_q;
	logic [CW-1:0]          cnt_q;

	logic                   valid_q;
	logic                   has_q;
	logic [CHILD_W-1:0]     child_q;
	logic                   last_q;
	logic                   trunc_q;

	logic [SW-1:0]          oldc_x;
	logic [SW-1:0]          newc_x;
	logic [SW-1:0]          parent_in_x;
	logic [SW-1:0]          smear;
	logic                   accept;
	logic                   invalid;
	logic [SW-1:0]          cand;
	eval_t                  flags;

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q == ST_RUN);
	assign accept       = start && !busy;
	assign oldc_x       = SW'(oldc_q);
	assign newc_x       = SW'(newc_q);
	assign parent_in_x  = SW'(parent_bucket);
	assign invalid      = (parent_in_x >= oldc_x) || (newc_x <= oldc_x);

	assign result_valid = valid_q;
	assign has_child    = has_q;
	assign child_bucket = child_q;
	assign last         = last_q;
	assign truncated    = trunc_q;

	always_comb begin
		smear = oldc_x;
		for (int i = 0; i < SMEAR_STEPS; i++) begin
			smear = smear | (smear >> (1 << i));
		end
	end

	pgsc_eval #(
		.SW(SW)
	) u_eval (
		.base  (base_q),
		.parent(SW'(parent_q)),
		.oldc  (oldc_x),
		.newc  (newc_x),
		.mask  (mask_q),
		.prev  (pend_q),
		.prev_v(pend_v_q),
		.cand  (cand),
		.flags (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldc_q <= BUCKET_BITS'(OLD_COUNT_RESET);
			newc_q <= BUCKET_BITS'(NEW_COUNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OLD_COUNT: oldc_q <= cfg_data;
				REG_NEW_COUNT: newc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= 1'b0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						parent_q <= parent_bucket;
						mask_q   <= smear;
						step_q   <= smear ^ (smear >> 1);
						base_q   <= smear ^ (smear >> 1);
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
						if (invalid) begin
							valid_q <= 1'b1;
							has_q   <= 1'b0;
							child_q <= '0;
							last_q  <= 1'b1;
							trunc_q <= 1'b0;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					base_q <= base_q + step_q;
					if (flags.stop) begin
						valid_q <= 1'b1;
						has_q   <= pend_v_q;
						child_q <= pend_v_q ? pend_q[CHILD_W-1:0] : '0;
						last_q  <= 1'b1;
						trunc_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (flags.keep) begin
						if (pend_v_q) begin
							valid_q <= 1'b1;
							has_q   <= 1'b1;
							child_q <= pend_q[CHILD_W-1:0];
							if (cnt_q == CW'(MAX_CHILDREN)) begin
								last_q  <= 1'b1;
								trunc_q <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								last_q  <= 1'b0;
								trunc_q <= 1'b0;
							end
						end
						pend_q   <= cand;
						pend_v_q <= 1'b1;
						cnt_q    <= cnt_q + CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && truncated) |-> (last && has_child))
		else $error("truncated result is not a final child");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !has_child) |-> (last && !truncated && (child_bucket == '0)))
		else $error("empty result malformed");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || (result_valid && last)))
		else $error("accepted transaction neither running nor answered");

	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("intermediate result while idle");

endmodule
`default_nettype wire
